### rtl/core/bounded_key_value_table_core_defines.svh
// Assertion helpers shared by the core RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BOUNDED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define BOUNDED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define BKV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bkv_pkg.sv
package bkv_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    // Fixed port field widths
    localparam int OP_BITS    = 3;
    localparam int FIELD_BITS = 32;
    localparam int RANK_BITS  = 7;
    localparam int COUNT_BITS = 7;

    typedef logic [OP_BITS-1:0] opcode_t;

    localparam opcode_t OP_INSERT = 3'd0;
    localparam opcode_t OP_UPDATE = 3'd1;
    localparam opcode_t OP_UPSERT = 3'd2;
    localparam opcode_t OP_ERASE  = 3'd3;
    localparam opcode_t OP_LOOKUP = 3'd4;
    localparam opcode_t OP_RANK   = 3'd5;

    typedef struct packed {
        opcode_t                opcode;
        logic [FIELD_BITS-1:0]  key_in;
        logic [FIELD_BITS-1:0]  value_in;
        logic [RANK_BITS-1:0]   rank_index;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [FIELD_BITS-1:0]  key_out;
        logic [FIELD_BITS-1:0]  value_out;
        logic [COUNT_BITS-1:0]  entry_count;
        logic                   is_empty;
    } rsp_t;

    // Sequencer to storage
    typedef struct packed {
        logic [ADDR_BITS-1:0]   rd_addr;
        logic                   wr_key_en;
        logic                   wr_val_en;
        logic [ADDR_BITS-1:0]   wr_addr;
        logic [KEY_BITS-1:0]    wr_key;
        logic [VALUE_BITS-1:0]  wr_val;
    } store_cmd_t;

endpackage

### rtl/core/bkv_req_if.sv
interface bkv_req_if;
    import bkv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     opcode;
    logic [FIELD_BITS-1:0]  key_in;
    logic [FIELD_BITS-1:0]  value_in;
    logic [RANK_BITS-1:0]   rank_index;

    modport source (output valid, opcode, key_in, value_in, rank_index, input ready);
    modport sink   (input valid, opcode, key_in, value_in, rank_index, output ready);
endinterface

### rtl/core/bkv_rsp_if.sv
interface bkv_rsp_if;
    import bkv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [FIELD_BITS-1:0]  key_out;
    logic [FIELD_BITS-1:0]  value_out;
    logic [COUNT_BITS-1:0]  entry_count;
    logic                   is_empty;

    modport source (output valid, ok, key_out, value_out, entry_count, is_empty,
                    input ready);
    modport sink   (input valid, ok, key_out, value_out, entry_count, is_empty,
                    output ready);
endinterface

### rtl/core/bkv_store.sv
module bkv_store (
    input  logic                             clk,
    input  bkv_pkg::store_cmd_t              cmd,
    output logic [bkv_pkg::KEY_BITS-1:0]     rd_key,
    output logic [bkv_pkg::VALUE_BITS-1:0]   rd_val
);
    import bkv_pkg::*;

    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    // One write and one shared read address, registered read data
    always_ff @(posedge clk)
    begin
        if (cmd.wr_key_en)
        begin
            key_mem[cmd.wr_addr] <= cmd.wr_key;
        end
        if (cmd.wr_val_en)
        begin
            val_mem[cmd.wr_addr] <= cmd.wr_val;
        end
        rd_key_reg <= key_mem[cmd.rd_addr];
        rd_val_reg <= val_mem[cmd.rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule

### rtl/core/bkv_ctrl.sv
`include "bounded_key_value_table_core_defines.svh"

module bkv_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  bkv_pkg::req_t                    req,
    input  logic                             out_free,
    output logic                             push,
    output bkv_pkg::rsp_t                    res,
    output bkv_pkg::store_cmd_t              cmd,
    input  logic [bkv_pkg::KEY_BITS-1:0]     rd_key,
    input  logic [bkv_pkg::VALUE_BITS-1:0]   rd_val
);
    import bkv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_RLOAD  = 3'd3;
    localparam logic [2:0] S_RCOUNT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_ZERO = '0;
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);

    logic [2:0]             state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    ord_reg, ord_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    opcode_t                op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [RANK_BITS-1:0]   rank_reg, rank_next;
    logic [KEY_BITS-1:0]    cand_key_reg, cand_key_next;
    logic [VALUE_BITS-1:0]  cand_val_reg, cand_val_next;
    logic                   ok_reg, ok_next;
    logic [FIELD_BITS-1:0]  kout_reg, kout_next;
    logic [FIELD_BITS-1:0]  vout_reg, vout_next;

    logic                   in_range;
    logic                   hit;
    logic                   full;
    logic [CNT_BITS-1:0]    idx_inc;
    logic [CNT_BITS-1:0]    idx_dec;
    logic [CNT_BITS-1:0]    ord_inc;

    assign in_range = idx_reg < count_reg;
    assign hit      = in_range && (rd_key == key_reg);
    assign full     = count_reg == CNT_FULL;
    assign idx_inc  = idx_reg + CNT_ONE;
    assign idx_dec  = idx_reg - CNT_ONE;
    assign ord_inc  = ord_reg + CNT_ONE;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        ord_next      = ord_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        rank_next     = rank_reg;
        cand_key_next = cand_key_reg;
        cand_val_next = cand_val_reg;
        ok_next       = ok_reg;
        kout_next     = kout_reg;
        vout_next     = vout_reg;
        req_ready     = 1'b0;
        push          = 1'b0;
        cmd.wr_key_en = 1'b0;
        cmd.wr_val_en = 1'b0;
        cmd.wr_addr   = idx_reg[ADDR_BITS-1:0];
        cmd.wr_key    = key_reg;
        cmd.wr_val    = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next   = req.opcode;
                    key_next  = KEY_BITS'(req.key_in);
                    val_next  = VALUE_BITS'(req.value_in);
                    rank_next = req.rank_index;
                    ok_next   = 1'b0;
                    kout_next = '0;
                    vout_next = '0;
                    idx_next  = CNT_ZERO;
                    ord_next  = CNT_ZERO;
                    unique case (req.opcode)
                        OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP:
                        begin
                            state_next = S_FIND;
                        end
                        OP_RANK:
                        begin
                            if (req.rank_index < count_reg)
                            begin
                                state_next = S_RLOAD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                // read data belongs to idx_reg
                if (hit)
                begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        OP_UPDATE, OP_UPSERT:
                        begin
                            cmd.wr_val_en = 1'b1;
                            ok_next       = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            ok_next   = 1'b1;
                            vout_next = FIELD_BITS'(rd_val);
                        end
                        OP_ERASE:
                        begin
                            ok_next = 1'b1;
                            if (idx_inc < count_reg)
                            begin
                                idx_next   = idx_inc;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
                else if (!in_range)
                begin
                    state_next = S_DONE;
                    if (((op_reg == OP_INSERT) || (op_reg == OP_UPSERT)) && !full)
                    begin
                        cmd.wr_key_en = 1'b1;
                        cmd.wr_val_en = 1'b1;
                        cmd.wr_addr   = count_reg[ADDR_BITS-1:0];
                        count_next    = count_reg + CNT_ONE;
                        ok_next       = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SHIFT:
            begin
                // move entry idx down to idx-1
                cmd.wr_key_en = 1'b1;
                cmd.wr_val_en = 1'b1;
                cmd.wr_addr   = idx_dec[ADDR_BITS-1:0];
                cmd.wr_key    = rd_key;
                cmd.wr_val    = rd_val;
                if (idx_inc < count_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    state_next = S_DONE;
                end
            end
            S_RLOAD:
            begin
                cand_key_next = rd_key;
                cand_val_next = rd_val;
                cnt_next      = CNT_ZERO;
                idx_next      = CNT_ZERO;
                state_next    = S_RCOUNT;
            end
            S_RCOUNT:
            begin
                if (!in_range)
                begin
                    if (cnt_reg == rank_reg)
                    begin
                        ok_next    = 1'b1;
                        kout_next  = FIELD_BITS'(cand_key_reg);
                        vout_next  = FIELD_BITS'(cand_val_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ord_next   = ord_inc;
                        idx_next   = ord_inc;
                        state_next = S_RLOAD;
                    end
                end
                else
                begin
                    if (rd_key < cand_key_reg)
                    begin
                        cnt_next = cnt_reg + CNT_ONE;
                    end
                    idx_next = idx_inc;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // read address is taken from idx_next so data lines up with idx_reg
        cmd.rd_addr = idx_next[ADDR_BITS-1:0];
    end

    assign res.ok          = ok_reg;
    assign res.key_out     = kout_reg;
    assign res.value_out   = vout_reg;
    assign res.entry_count = COUNT_BITS'(count_reg);
    assign res.is_empty    = count_reg == CNT_ZERO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_ZERO;
            idx_reg   <= CNT_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg      <= ord_next;
        cnt_reg      <= cnt_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        rank_reg     <= rank_next;
        cand_key_reg <= cand_key_next;
        cand_val_reg <= cand_val_next;
        ok_reg       <= ok_next;
        kout_reg     <= kout_next;
        vout_reg     <= vout_next;
    end

    `BKV_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_FULL,
                     "entry count above capacity")
    `BKV_ASSERT_IMPL(a_write_state, cmd.wr_key_en || cmd.wr_val_en,
                     (state_reg == S_FIND) || (state_reg == S_SHIFT),
                     "store write outside scan or shift")
    `BKV_ASSERT_NEXT(a_count_hold, (state_reg == S_IDLE) || (state_reg == S_DONE),
                     $stable(count_reg), "entry count moved while not working")
    `BKV_ASSERT_IMPL(a_rank_cnt, state_reg == S_RCOUNT, cnt_reg <= idx_reg,
                     "rank tally ahead of scan")

endmodule

### rtl/core/bounded_key_value_table_core.sv
// Channel  Dir  Fields                                        Accepted when
// req      in   opcode, key_in, value_in, rank_index          req.valid && req.ready
// rsp      out  ok, key_out, value_out, entry_count, is_empty  rsp.valid && rsp.ready
//
// One request at a time; N = stored entries, s = matching slot.
// Insert/update/lookup: accept, scan the N entries until a match or the end, done.
// Erase of slot s: accept, scan to slot s, shift each later entry down one slot, done.
// Select-by-rank: one key compare per cycle on one read port.
// Reset clears the count, not the stored pairs; pairs are read only below the count.
// A finished result waits in the rsp register while the next request is accepted.
module bounded_key_value_table_core (
    input  logic    clk,
    input  logic    rst_n,
    bkv_req_if.sink req,
    bkv_rsp_if.source rsp
);
    import bkv_pkg::*;

    req_t       req_pay;
    rsp_t       res;
    store_cmd_t cmd;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic       push;
    logic       out_free;

    logic       out_valid_reg;
    rsp_t       out_data_reg;

    assign req_pay.opcode     = req.opcode;
    assign req_pay.key_in     = req.key_in;
    assign req_pay.value_in   = req.value_in;
    assign req_pay.rank_index = req.rank_index;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    bkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_pay),
        .out_free  (out_free),
        .push      (push),
        .res       (res),
        .cmd       (cmd),
        .rd_key    (rd_key),
        .rd_val    (rd_val)
    );

    bkv_store u_store (
        .clk    (clk),
        .cmd    (cmd),
        .rd_key (rd_key),
        .rd_val (rd_val)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_data_reg.ok;
    assign rsp.key_out     = out_data_reg.key_out;
    assign rsp.value_out   = out_data_reg.value_out;
    assign rsp.entry_count = out_data_reg.entry_count;
    assign rsp.is_empty    = out_data_reg.is_empty;

endmodule

### tb/sv/tb_bounded_key_value_table_core.sv
`timescale 1ns / 100ps

module tb_bounded_key_value_table_core;
    import bkv_pkg::*;

    localparam int HALF_PERIOD  = 10;
    // Worst quiet stretch: rank select on a full table plus the
    // long receiver hold and a gap; taken several times over.
    localparam int STALL_LIMIT  = 30000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_EVERY   = 800;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE_CYCLES = 100;
    localparam int PRINT_LIMIT  = 40;

    // Opcodes with no function in the block
    localparam opcode_t OP_SPARE_LO = 3'd6;
    localparam opcode_t OP_SPARE_HI = 3'd7;

    // One queued request; drain makes the sender wait until all results are back
    typedef struct packed {
        req_t req;
        logic drain;
    } stim_t;

    logic clk;
    logic rst_n;

    bkv_req_if req_bus ();
    bkv_rsp_if rsp_bus ();

    bounded_key_value_table_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Table mirror: pairs in insertion order, as the block keeps them
    logic [KEY_BITS-1:0]   table_keys [CAPACITY];
    logic [VALUE_BITS-1:0] table_vals [CAPACITY];
    int                    table_count = 0;

    stim_t       stim_q [$];      // requests not yet offered
    rsp_t        pending_rsp [$]; // results owed by the block, oldest first
    logic [31:0] key_pool [$];    // small key set so hits are common
    logic [31:0] fresh_keys [$];  // keys used to fill the table

    logic req_fire = 1'b0;        // request taken at the last rising edge
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    int   next_hold_at = 200;
    int   rsp_count = 0;
    int   mismatch_count = 0;
    int   stall_cycles = 0;

    //--------------------------------------------------------------------
    // Clock and reset
    //--------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.opcode     = OP_INSERT;
        req_bus.key_in     = '0;
        req_bus.value_in   = '0;
        req_bus.rank_index = '0;
        rsp_bus.ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    //--------------------------------------------------------------------
    // Predictor: applies one request to the mirror and returns the result
    //--------------------------------------------------------------------
    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   slot;
        int   less;
        int   i;
        int   j;
        res  = '0;
        slot = -1;
        for (i = 0; i < table_count; i++)
            if (slot < 0 && table_keys[i] == r.key_in)
                slot = i;

        case (r.opcode)
            OP_INSERT:
                if (slot < 0 && table_count < CAPACITY)
                begin
                    table_keys[table_count] = r.key_in;
                    table_vals[table_count] = r.value_in;
                    table_count++;
                    res.ok = 1'b1;
                end
            OP_UPDATE:
                if (slot >= 0)
                begin
                    table_vals[slot] = r.value_in;
                    res.ok = 1'b1;
                end
            OP_UPSERT:
                if (slot >= 0)
                begin
                    table_vals[slot] = r.value_in;
                    res.ok = 1'b1;
                end
                else if (table_count < CAPACITY)
                begin
                    table_keys[table_count] = r.key_in;
                    table_vals[table_count] = r.value_in;
                    table_count++;
                    res.ok = 1'b1;
                end
            OP_ERASE:
                if (slot >= 0)
                begin
                    // later entries move down one place
                    for (i = slot; i < table_count - 1; i++)
                    begin
                        table_keys[i] = table_keys[i + 1];
                        table_vals[i] = table_vals[i + 1];
                    end
                    table_count--;
                    res.ok = 1'b1;
                end
            OP_LOOKUP:
                if (slot >= 0)
                begin
                    res.ok        = 1'b1;
                    res.value_out = table_vals[slot];
                end
            OP_RANK:
                // pick the entry with exactly rank_index smaller keys
                if (int'(r.rank_index) < table_count)
                    for (i = 0; i < table_count; i++)
                    begin
                        less = 0;
                        for (j = 0; j < table_count; j++)
                            if (table_keys[j] < table_keys[i])
                                less++;
                        if (!res.ok && less == int'(r.rank_index))
                        begin
                            res.ok        = 1'b1;
                            res.key_out   = table_keys[i];
                            res.value_out = table_vals[i];
                        end
                    end
            default:
                ;
        endcase

        res.entry_count = COUNT_BITS'(table_count);
        res.is_empty    = (table_count == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch: %s on response %0d, got %h want %h",
                     field, rsp_count, got, want);
    endtask

    //--------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------
    task automatic push_req(input opcode_t op, input logic [31:0] key,
                            input logic [31:0] value, input logic [6:0] rank,
                            input logic drain = 1'b0);
        stim_t s;
        s.req.opcode     = op;
        s.req.key_in     = key;
        s.req.value_in   = value;
        s.req.rank_index = rank;
        s.drain          = drain;
        stim_q.push_back(s);
    endtask

    // Mixed traffic over the first pool_size pool keys, with some strays
    task automatic push_random(input int pool_size);
        int          pick;
        opcode_t     op;
        logic [31:0] key;
        logic [6:0]  rank;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            op = OP_INSERT;
        else if (pick < 32)
            op = OP_UPDATE;
        else if (pick < 47)
            op = OP_UPSERT;
        else if (pick < 65)
            op = OP_ERASE;
        else if (pick < 83)
            op = OP_LOOKUP;
        else if (pick < 96)
            op = OP_RANK;
        else if (pick < 98)
            op = OP_SPARE_LO;
        else
            op = OP_SPARE_HI;

        if ($urandom_range(0, 19) == 0)
            key = $urandom;
        else
            key = key_pool[$urandom_range(0, pool_size - 1)];

        if ($urandom_range(0, 4) == 0)
            rank = 7'($urandom_range(0, 127));
        else
            rank = 7'($urandom_range(0, pool_size));

        push_req(op, key, $urandom, rank);
    endtask

    //--------------------------------------------------------------------
    // Request driver: changes on the falling edge, one valid update per edge
    //--------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_req
        stim_t nxt;
        logic  offer;
        offer = req_bus.valid && !req_fire;   // still waiting to be taken
        if (rst_n && !offer)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain && pending_rsp.size() != 0))
            begin
                // idle bursts, none in the tail of the run
                if (stim_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 12) - 1;
                else
                begin
                    nxt = stim_q.pop_front();
                    req_bus.opcode     <= nxt.req.opcode;
                    req_bus.key_in     <= nxt.req.key_in;
                    req_bus.value_in   <= nxt.req.value_in;
                    req_bus.rank_index <= nxt.req.rank_index;
                    offer = 1'b1;
                end
            end
        end
        req_bus.valid <= offer;
    end

    //--------------------------------------------------------------------
    // Result ready: random stall bursts plus a long hold every so often so
    // the held result blocks the next request
    //--------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_rsp_ready
        logic take;
        take = 1'b0;
        if (rst_n)
        begin
            if (rsp_count >= next_hold_at && stim_q.size() >= CALM_TAIL)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end
            if (hold_left > 0)
                hold_left--;
            else if (recv_gap > 0)
                recv_gap--;
            else if (stim_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 12) - 1;
            else
                take = 1'b1;
        end
        rsp_bus.ready <= take;
    end

    //--------------------------------------------------------------------
    // Monitor: results checked first, then the newly taken request predicted
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        req_t r;
        rsp_t want;
        req_fire <= req_bus.valid && req_bus.ready;

        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("response with no request", 32'(rsp_bus.ok), '0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_bus.ok !== want.ok)
                    report_mismatch("ok", 32'(rsp_bus.ok), 32'(want.ok));
                if (rsp_bus.key_out !== want.key_out)
                    report_mismatch("key_out", rsp_bus.key_out, want.key_out);
                if (rsp_bus.value_out !== want.value_out)
                    report_mismatch("value_out", rsp_bus.value_out, want.value_out);
                if (rsp_bus.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_bus.entry_count),
                                    32'(want.entry_count));
                if (rsp_bus.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(rsp_bus.is_empty),
                                    32'(want.is_empty));
            end
            rsp_count++;
        end

        if (req_bus.valid && req_bus.ready)
        begin
            r.opcode     = req_bus.opcode;
            r.key_in     = req_bus.key_in;
            r.value_in   = req_bus.value_in;
            r.rank_index = req_bus.rank_index;
            pending_rsp.push_back(apply_request(r));
        end
    end

    // Watchdog: too long with no request or result moving
    always @(posedge clk)
    begin : stall_watch
        if (!rst_n || (req_bus.valid && req_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Request stream
    //--------------------------------------------------------------------
    initial
    begin : stimulus
        int          i;
        int          j;
        logic [31:0] tmp;

        // Directed: empty table, field extremes, every opcode, failure paths short of a full table
        push_req(OP_LOOKUP, 32'h0000_0000, 32'h0, 7'd0);
        push_req(OP_RANK,   32'h0000_0000, 32'h0, 7'd0);          // empty table
        push_req(OP_ERASE,  32'h1234_5678, 32'h0, 7'd0);          // absent key
        push_req(OP_UPDATE, 32'h1234_5678, 32'hFFFF_FFFF, 7'd0);  // absent key
        push_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 7'd0);
        push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 7'd127);
        push_req(OP_INSERT, 32'h0000_0000, 32'h5555_5555, 7'd0);  // present key
        push_req(OP_UPSERT, 32'h8000_0001, 32'hAAAA_AAAA, 7'd0);  // inserts
        push_req(OP_UPSERT, 32'h0000_0000, 32'h1234_5678, 7'd0);  // updates
        push_req(OP_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 7'd0);
        push_req(OP_LOOKUP, 32'h0000_0000, 32'h0, 7'd0);
        push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 7'd0);
        push_req(OP_RANK,   32'h0, 32'h0, 7'd0);
        push_req(OP_RANK,   32'h0, 32'h0, 7'd1);
        push_req(OP_RANK,   32'h0, 32'h0, 7'd2);
        push_req(OP_RANK,   32'h0, 32'h0, 7'd3);                  // rank == count
        push_req(OP_RANK,   32'h0, 32'h0, 7'd127);
        push_req(OP_SPARE_LO, $urandom, $urandom, 7'd0);
        push_req(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
        push_req(OP_ERASE,  32'h0000_0000, 32'h0, 7'd0);          // head entry, shifts
        push_req(OP_LOOKUP, 32'h0000_0000, 32'h0, 7'd0);
        push_req(OP_ERASE,  32'hFFFF_FFFF, 32'h0, 7'd0);
        push_req(OP_ERASE,  32'h8000_0001, 32'h0, 7'd0);          // back to empty
        push_req(OP_LOOKUP, 32'h8000_0001, 32'h0, 7'd0);

        // Random traffic over a small key set
        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFF);
        for (i = 2; i < 40; i++)
            key_pool.push_back($urandom);
        for (i = 0; i < 600; i++)
            push_random(16);

        // Fill to capacity from a drained state, then poke the full table
        push_req(OP_LOOKUP, key_pool[0], 32'h0, 7'd0, 1'b1);
        for (i = 0; i < 70; i++)
        begin
            tmp = $urandom;
            fresh_keys.push_back(tmp);
            push_req((i % 5 == 4) ? OP_UPSERT : OP_INSERT, tmp, $urandom, 7'd0);
            if (i % 8 == 0)
                push_req(OP_LOOKUP, fresh_keys[$urandom_range(0, i)], 32'h0, 7'd0);
        end
        push_req(OP_INSERT, $urandom, $urandom, 7'd0);            // full table
        push_req(OP_UPSERT, $urandom, $urandom, 7'd0);            // full, absent
        push_req(OP_UPSERT, fresh_keys[5], $urandom, 7'd0);
        push_req(OP_INSERT, fresh_keys[0], $urandom, 7'd0);
        push_req(OP_RANK, 32'h0, 32'h0, 7'd0);
        push_req(OP_RANK, 32'h0, 32'h0, 7'(CAPACITY - 1));
        push_req(OP_RANK, 32'h0, 32'h0, 7'($urandom_range(0, CAPACITY - 1)));
        push_req(OP_RANK, 32'h0, 32'h0, 7'(CAPACITY));

        // Erase the fresh keys again in random order so the shift distance varies
        for (i = fresh_keys.size() - 1; i > 0; i--)
        begin
            j             = $urandom_range(0, i);
            tmp           = fresh_keys[i];
            fresh_keys[i] = fresh_keys[j];
            fresh_keys[j] = tmp;
        end
        for (i = 0; i < fresh_keys.size(); i++)
        begin
            push_req(OP_ERASE, fresh_keys[i], $urandom, 7'd0);
            if ($urandom_range(0, 9) == 0)
                push_req(OP_RANK, 32'h0, 32'h0, 7'($urandom_range(0, CAPACITY - 1)));
            if ($urandom_range(0, 5) == 0)
                push_req(OP_LOOKUP, fresh_keys[$urandom_range(0, fresh_keys.size() - 1)],
                         32'h0, 7'd0);
        end

        // Wider key set, deeper table; the tail of this runs with no idling
        push_req(OP_RANK, 32'h0, 32'h0, 7'd0, 1'b1);
        for (i = 0; i < 800; i++)
            push_random(40);

        // Let everything drain, then watch for stray results
        do
            @(posedge clk);
        while (stim_q.size() != 0 || req_bus.valid || pending_rsp.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
            report_mismatch("results still owed", 32'(pending_rsp.size()), '0);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### bounded_key_value_table_core.f
+incdir+rtl/core
rtl/core/bkv_pkg.sv
rtl/core/bkv_req_if.sv
rtl/core/bkv_rsp_if.sv
rtl/core/bkv_store.sv
rtl/core/bkv_ctrl.sv
rtl/core/bounded_key_value_table_core.sv
tb/sv/tb_bounded_key_value_table_core.sv
